[hdl/brp_pkg.sv]
// Shared types, codes and reset values of the buffer recycle pool.
`default_nettype none

package brp_pkg;

    // request codes
    localparam logic [2:0] REQ_RELEASE = 3'd0;
    localparam logic [2:0] REQ_TICK    = 3'd1;
    localparam logic [2:0] REQ_ALLOC   = 3'd2;
    localparam logic [2:0] REQ_EVICT   = 3'd3;
    localparam logic [2:0] REQ_FLUSH   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREED = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_MAX_BYTES   = 2'd1;
    localparam logic [1:0] CFG_FIF         = 2'd2;

    localparam int DEFERRED_DEPTH_DEF = 32;
    localparam int POOL_DEPTH_DEF     = 16;

    localparam logic [4:0]  MAX_ENTRIES_RST = 5'd16;
    localparam logic [35:0] MAX_BYTES_RST   = 36'd268435456;
    localparam logic [4:0]  FIF_RST         = 5'd2;

    // width used to compare pool counts against the entry limit
    localparam int CMP_W = 9;

    typedef struct packed {
        logic [4:0]  mem_type;
        logic [11:0] usage;
        logic [15:0] id;
    } info_t;

    typedef struct packed {
        info_t       info;
        logic [31:0] size;
        logic [31:0] stamp;
    } def_entry_t;

    typedef struct packed {
        info_t       info;
        logic [31:0] size;
    } pool_entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        hit;
        logic [15:0] id;
        logic [31:0] size;
        logic [4:0]  mem_type;
        logic        status;
    } result_t;

endpackage

`default_nettype wire

[hdl/buffer_recycle_pool.sv]
// Top level of the buffer recycle pool: deferred list, pool and result queue.
`default_nettype none

//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-------------------------
//  request | req_type buffer_id byte_size usage_flags  | req_valid / req_stall
//          | mem_type frame_number                     |
//  result  | kind hit out_id out_size out_mem_type     | rsp_valid / rsp_stall
//          | status pool_total last                    |
//  config  | cfg_index cfg_data                        | cfg_we, no wait
//
//  One item at a time. A release passes through ST_REL, ST_FIN, ST_D_RD and
//  ST_D_LD after acceptance. A tick reads and checks each deferred entry
//  (ST_T_RD, ST_T_CHK) plus ST_T_MV per swap-and-pop move; allocate reads and
//  checks each pooled entry (ST_S_RD, ST_S_CHK); each evicted buffer costs a
//  full pool scan; flush reads and pushes each stored entry. Every result is
//  queued and drained via ST_D_RD and ST_D_LD; the queue read is registered.
//  Reset clears counts and control at once; no clearing pass is needed.
//  A stalled result holds the drain; the next item is taken while the last
//  result of the previous item still waits, and pool_total stays with it.

module buffer_recycle_pool #(
    parameter int DEFERRED_DEPTH = brp_pkg::DEFERRED_DEPTH_DEF,
    parameter int POOL_DEPTH     = brp_pkg::POOL_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [35:0] cfg_data,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [2:0]  req_type,
    input  wire logic [15:0] buffer_id,
    input  wire logic [31:0] byte_size,
    input  wire logic [11:0] usage_flags,
    input  wire logic [4:0]  mem_type,
    input  wire logic [31:0] frame_number,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [1:0]       kind,
    output logic             hit,
    output logic [15:0]      out_id,
    output logic [31:0]      out_size,
    output logic [4:0]       out_mem_type,
    output logic             status,
    output logic [35:0]      pool_total,
    output logic             last
);
    import brp_pkg::*;

    localparam int DW  = $clog2(DEFERRED_DEPTH);
    localparam int DCW = $clog2(DEFERRED_DEPTH + 1);
    localparam int PW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int PCW = $clog2(POOL_DEPTH + 1);
    localparam int IW  = (DCW > PCW) ? DCW : PCW;
    localparam int RQ_DEPTH = DEFERRED_DEPTH + POOL_DEPTH + 1;
    localparam int RW  = $clog2(RQ_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE, ST_REL, ST_T_RD, ST_T_CHK, ST_T_MV, ST_S_RD, ST_S_CHK, ST_S_DONE,
        ST_RM_RD, ST_RM_WR, ST_E_TEST, ST_F_RD, ST_F_PUSH, ST_FIN, ST_D_RD, ST_D_LD
    } state_t;

    // configuration registers
    logic [4:0]  max_entries_reg;
    logic [35:0] max_bytes_reg;
    logic [4:0]  fif_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RST;
            max_bytes_reg   <= MAX_BYTES_RST;
            fif_reg         <= FIF_RST;
        end
        else if (cfg_we)
        begin
            priority case (cfg_index)
                CFG_MAX_ENTRIES: max_entries_reg <= cfg_data[4:0];
                CFG_MAX_BYTES:   max_bytes_reg   <= cfg_data;
                CFG_FIF:         fif_reg         <= cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    state_t          state_reg;
    logic [2:0]      op_reg;
    logic [15:0]     id_reg;
    logic [31:0]     size_reg;
    logic [11:0]     usage_reg;
    logic [4:0]      mem_reg;
    logic [31:0]     frame_reg;
    logic            st_reg;
    logic            phase_reg;      // flush: 0 deferred list, 1 pool
    logic [DCW-1:0]  dcount_reg;
    logic [PCW-1:0]  pcount_reg;
    logic [35:0]     bytes_reg;
    logic [IW-1:0]   idx_reg;
    logic [PW-1:0]   best_reg;
    logic [31:0]     best_size_reg;
    info_t           best_info_reg;
    logic            found_reg;
    logic [RW:0]     rq_cnt_reg;
    logic [RW:0]     rd_reg;
    logic            rsp_valid_reg;
    result_t         out_reg;
    logic            last_reg;
    logic [35:0]     pool_total_reg;

    // memories
    def_entry_t  def_mem [DEFERRED_DEPTH];
    pool_entry_t pool_mem [POOL_DEPTH];
    result_t     rq_mem [RQ_DEPTH];

    def_entry_t  def_q;
    pool_entry_t pool_q;
    result_t     rq_q;

    logic        def_we, pool_we, rq_we;
    logic [DW-1:0] def_waddr, def_raddr;
    logic [PW-1:0] pool_waddr, pool_raddr;
    def_entry_t  def_wdata;
    pool_entry_t pool_wdata;
    result_t     rq_wdata;

    // datapath decisions
    logic [DCW-1:0] dcount_m1;
    logic [PCW-1:0] pcount_m1;
    logic [31:0]    age;
    logic           aged, to_pool, alloc_match, evict_match;
    logic [36:0]    bytes_sum;
    logic [33:0]    cap;
    logic           load_out;

    assign dcount_m1 = dcount_reg - DCW'(1);
    assign pcount_m1 = pcount_reg - PCW'(1);
    assign age       = frame_reg - def_q.stamp;
    assign aged      = age >= 32'(fif_reg);
    assign bytes_sum = 37'(bytes_reg) + 37'(def_q.size);
    assign to_pool   = (CMP_W'(pcount_reg) < CMP_W'(max_entries_reg))
                    && (CMP_W'(pcount_reg) < CMP_W'(POOL_DEPTH))
                    && (def_q.size != 32'd0)
                    && (bytes_sum <= 37'(max_bytes_reg));
    assign cap         = {size_reg, 2'b00};
    assign alloc_match = (pool_q.info.usage == usage_reg) && (pool_q.size >= size_reg)
                      && (34'(pool_q.size) <= cap)
                      && (!found_reg || (pool_q.size < best_size_reg));
    assign evict_match = pool_q.size > best_size_reg;
    // the output register takes the next queued result when it is free
    assign load_out    = (state_reg == ST_D_LD) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        def_raddr  = idx_reg[DW-1:0];
        pool_raddr = idx_reg[PW-1:0];
        if (state_reg == ST_T_CHK)
            def_raddr = dcount_m1[DW-1:0];
        if (state_reg == ST_RM_RD)
            pool_raddr = pcount_reg[PW-1:0];

        def_we    = 1'b0;
        def_waddr = dcount_reg[DW-1:0];
        def_wdata = def_q;
        pool_we    = 1'b0;
        pool_waddr = pcount_reg[PW-1:0];
        pool_wdata = '{info: def_q.info, size: def_q.size};
        rq_we    = 1'b0;
        rq_wdata = '{kind: KIND_FREED, hit: 1'b0, id: def_q.info.id, size: def_q.size,
                     mem_type: def_q.info.mem_type, status: 1'b0};

        unique case (state_reg)
            ST_REL:
            begin
                def_we    = dcount_reg < DCW'(DEFERRED_DEPTH);
                def_wdata = '{info: '{mem_type: mem_reg, usage: usage_reg, id: id_reg},
                              size: size_reg, stamp: frame_reg};
            end
            ST_T_CHK:
            begin
                pool_we = aged && to_pool;
                rq_we   = aged && !to_pool;
            end
            ST_T_MV:
            begin
                def_we    = 1'b1;
                def_waddr = idx_reg[DW-1:0];
            end
            ST_S_DONE:
            begin
                rq_we = 1'b1;
                if (op_reg == REQ_ALLOC)
                begin
                    if (found_reg)
                        rq_wdata = '{kind: KIND_ALLOC, hit: 1'b1, id: best_info_reg.id,
                                     size: best_size_reg, mem_type: best_info_reg.mem_type,
                                     status: 1'b0};
                    else
                        rq_wdata = '{kind: KIND_ALLOC, hit: 1'b0, id: 16'd0, size: 32'd0,
                                     mem_type: 5'd0, status: 1'b0};
                end
                else
                    rq_wdata = '{kind: KIND_FREED, hit: 1'b0, id: best_info_reg.id,
                                 size: best_size_reg, mem_type: best_info_reg.mem_type,
                                 status: 1'b0};
            end
            ST_RM_WR:
            begin
                pool_we    = 1'b1;
                pool_waddr = best_reg;
                pool_wdata = pool_q;
            end
            ST_F_PUSH:
            begin
                rq_we = 1'b1;
                if (phase_reg)
                    rq_wdata = '{kind: KIND_FREED, hit: 1'b0, id: pool_q.info.id,
                                 size: pool_q.size, mem_type: pool_q.info.mem_type,
                                 status: 1'b0};
            end
            ST_FIN:
            begin
                rq_we    = 1'b1;
                rq_wdata = '{kind: KIND_DONE, hit: 1'b0, id: 16'd0, size: 32'd0,
                             mem_type: 5'd0, status: st_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        def_q <= def_mem[def_raddr];
        if (def_we)
            def_mem[def_waddr] <= def_wdata;
    end

    always_ff @(posedge clk)
    begin
        pool_q <= pool_mem[pool_raddr];
        if (pool_we)
            pool_mem[pool_waddr] <= pool_wdata;
    end

    always_ff @(posedge clk)
    begin
        rq_q <= rq_mem[rd_reg[RW-1:0]];
        if (rq_we)
            rq_mem[rq_cnt_reg[RW-1:0]] <= rq_wdata;
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= REQ_RELEASE;
            id_reg         <= '0;
            size_reg       <= '0;
            usage_reg      <= '0;
            mem_reg        <= '0;
            frame_reg      <= '0;
            st_reg         <= 1'b0;
            phase_reg      <= 1'b0;
            dcount_reg     <= '0;
            pcount_reg     <= '0;
            bytes_reg      <= '0;
            idx_reg        <= '0;
            best_reg       <= '0;
            best_size_reg  <= '0;
            best_info_reg  <= '0;
            found_reg      <= 1'b0;
            rq_cnt_reg     <= '0;
            rd_reg         <= '0;
            rsp_valid_reg  <= 1'b0;
            out_reg        <= '0;
            last_reg       <= 1'b0;
            pool_total_reg <= '0;
        end
        else
        begin
            // show a fresh result, or drop the shown one once taken
            if (load_out)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
            if (rq_we)
                rq_cnt_reg <= rq_cnt_reg + (RW+1)'(1);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        op_reg        <= req_type;
                        id_reg        <= buffer_id;
                        size_reg      <= byte_size;
                        usage_reg     <= usage_flags;
                        mem_reg       <= mem_type;
                        frame_reg     <= frame_number;
                        st_reg        <= 1'b0;
                        phase_reg     <= 1'b0;
                        idx_reg       <= '0;
                        best_reg      <= '0;
                        best_size_reg <= '0;
                        found_reg     <= 1'b0;
                        rq_cnt_reg    <= '0;
                        priority case (req_type)
                            REQ_RELEASE: state_reg <= ST_REL;
                            REQ_TICK:    state_reg <= ST_T_RD;
                            REQ_ALLOC:   state_reg <= ST_S_RD;
                            REQ_EVICT:   state_reg <= ST_E_TEST;
                            REQ_FLUSH:   state_reg <= ST_F_RD;
                            default:     state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_REL:
                begin
                    if (dcount_reg < DCW'(DEFERRED_DEPTH))
                        dcount_reg <= dcount_reg + DCW'(1);
                    else
                        st_reg <= 1'b1;
                    state_reg <= ST_FIN;
                end
                ST_T_RD:
                begin
                    if (idx_reg < IW'(dcount_reg))
                        state_reg <= ST_T_CHK;
                    else
                        state_reg <= ST_FIN;
                end
                ST_T_CHK:
                begin
                    if (aged)
                    begin
                        if (to_pool)
                        begin
                            pcount_reg <= pcount_reg + PCW'(1);
                            bytes_reg  <= bytes_sum[35:0];
                        end
                        dcount_reg <= dcount_m1;
                        // last entry needs no move
                        if (idx_reg == IW'(dcount_m1))
                            state_reg <= ST_T_RD;
                        else
                            state_reg <= ST_T_MV;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= ST_T_RD;
                    end
                end
                ST_T_MV:
                    state_reg <= ST_T_RD;
                ST_S_RD:
                begin
                    if (idx_reg < IW'(pcount_reg))
                        state_reg <= ST_S_CHK;
                    else
                        state_reg <= ST_S_DONE;
                end
                ST_S_CHK:
                begin
                    if ((op_reg == REQ_ALLOC) ? alloc_match : evict_match)
                    begin
                        best_reg      <= idx_reg[PW-1:0];
                        best_size_reg <= pool_q.size;
                        best_info_reg <= pool_q.info;
                        found_reg     <= 1'b1;
                    end
                    idx_reg   <= idx_reg + IW'(1);
                    state_reg <= ST_S_RD;
                end
                ST_S_DONE:
                begin
                    if (found_reg)
                    begin
                        bytes_reg  <= bytes_reg - 36'(best_size_reg);
                        pcount_reg <= pcount_m1;
                        if (PCW'(best_reg) == pcount_m1)
                            state_reg <= (op_reg == REQ_ALLOC) ? ST_D_RD : ST_E_TEST;
                        else
                            state_reg <= ST_RM_RD;
                    end
                    else
                        state_reg <= ST_D_RD;
                    rd_reg <= '0;
                end
                ST_RM_RD:
                    state_reg <= ST_RM_WR;
                ST_RM_WR:
                begin
                    rd_reg    <= '0;
                    state_reg <= (op_reg == REQ_ALLOC) ? ST_D_RD : ST_E_TEST;
                end
                ST_E_TEST:
                begin
                    idx_reg       <= '0;
                    best_reg      <= '0;
                    best_size_reg <= '0;
                    found_reg     <= 1'b0;
                    if ((bytes_reg > max_bytes_reg) && (pcount_reg != '0))
                        state_reg <= ST_S_RD;
                    else
                        state_reg <= ST_FIN;
                end
                ST_F_RD:
                begin
                    if (!phase_reg)
                    begin
                        if (idx_reg < IW'(dcount_reg))
                            state_reg <= ST_F_PUSH;
                        else
                        begin
                            phase_reg <= 1'b1;
                            idx_reg   <= '0;
                        end
                    end
                    else if (idx_reg < IW'(pcount_reg))
                        state_reg <= ST_F_PUSH;
                    else
                    begin
                        dcount_reg <= '0;
                        pcount_reg <= '0;
                        bytes_reg  <= '0;
                        state_reg  <= ST_FIN;
                    end
                end
                ST_F_PUSH:
                begin
                    idx_reg   <= idx_reg + IW'(1);
                    state_reg <= ST_F_RD;
                end
                ST_FIN:
                begin
                    rd_reg    <= '0;
                    state_reg <= ST_D_RD;
                end
                ST_D_RD:
                    state_reg <= ST_D_LD;
                ST_D_LD:
                begin
                    // advance only when the output register is free
                    if (load_out)
                    begin
                        out_reg        <= rq_q;
                        pool_total_reg <= bytes_reg;
                        last_reg       <= rd_reg == rq_cnt_reg - (RW+1)'(1);
                        if (rd_reg == rq_cnt_reg - (RW+1)'(1))
                            state_reg <= ST_IDLE;
                        else
                        begin
                            rd_reg    <= rd_reg + (RW+1)'(1);
                            state_reg <= ST_D_RD;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign req_stall    = state_reg != ST_IDLE;
    assign rsp_valid    = rsp_valid_reg;
    assign kind         = out_reg.kind;
    assign hit          = out_reg.hit;
    assign out_id       = out_reg.id;
    assign out_size     = out_reg.size;
    assign out_mem_type = out_reg.mem_type;
    assign status       = out_reg.status;
    assign pool_total   = pool_total_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire
